[hw/rtl/tps_pkg.sv]
// Shared types and constants for the text paragraph segmenter.
`default_nettype none
package tps_pkg;

	localparam int LEAD_DEPTH_DEF = 32;

	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_TEXT  = 2'd1;
	localparam logic [1:0] REQ_END   = 2'd2;

	localparam logic [1:0] REG_NL  = 2'd0;
	localparam logic [1:0] REG_BL  = 2'd1;
	localparam logic [1:0] REG_IND = 2'd2;
	localparam logic [1:0] REG_IGN = 2'd3;

	localparam logic [15:0] CU_TAB   = 16'd9;
	localparam logic [15:0] CU_LF    = 16'd10;
	localparam logic [15:0] CU_VT    = 16'd11;
	localparam logic [15:0] CU_FF    = 16'd12;
	localparam logic [15:0] CU_CR    = 16'd13;
	localparam logic [15:0] CU_SPACE = 16'd32;

	localparam logic [11:0] COUNT_MAX = 12'd4095;
	localparam logic [7:0]  RUN_MAX   = 8'd255;
	localparam logic [5:0]  IGN_RESET = 6'd4;

	typedef enum logic [2:0] {
		EV_TEXT   = 3'd0,
		EV_PBEGIN = 3'd1,
		EV_PEND   = 3'd2,
		EV_TBEGIN = 3'd3,
		EV_TEND   = 3'd4,
		EV_SECEND = 3'd5
	} ev_kind_t;

	typedef enum logic [1:0] {
		SRC_ZERO,
		SRC_TERM,
		SRC_LEAD,
		SRC_UNIT
	} src_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_CHAPTER,
		OP_CLR_CR,
		OP_SET_CR,
		OP_LEAD_ADD,
		OP_LINE_START,
		OP_LEAD_NEXT,
		OP_LINE_END,
		OP_CLR_TITLE,
		OP_FINISH
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_TXT,
		ST_IND_PEND,
		ST_IND_PBEGIN,
		ST_LEAD,
		ST_UNIT,
		ST_LE_TEXT,
		ST_LE_TEND,
		ST_LE_PEND,
		ST_LE_PBEGIN,
		ST_SECEND,
		ST_END_PEND,
		ST_TBEGIN,
		ST_CH_PBEGIN,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic       nl;
		logic       bl;
		logic       ind;
		logic [5:0] ign;
	} cfg_t;

	typedef struct packed {
		logic     emit;
		ev_kind_t kind;
		src_t     src;
		op_t      op;
	} cmd_t;

	typedef struct packed {
		logic       out_free;
		logic [1:0] req;
		logic       title_req;
		logic       line_blank;
		logic       cr_pend;
		logic       title_act;
		logic       u_lf;
		logic       u_cr;
		logic       u_blank;
		logic       brk;
		logic       ind_brk;
		logic       lead_empty;
		logic       lead_last;
	} stat_t;

endpackage
`default_nettype wire

[hw/rtl/tps_regs.sv]
// Configuration register file behind the APB-style port.
`default_nettype none
module tps_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output tps_pkg::cfg_t     cfg
);
	import tps_pkg::*;

	cfg_t cfg_q;
	logic wr;
	logic [1:0] idx;

	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nl  <= 1'b1;
			cfg_q.bl  <= 1'b0;
			cfg_q.ind <= 1'b0;
			cfg_q.ign <= IGN_RESET;
		end else if (wr) begin
			case (idx)
				REG_NL:  cfg_q.nl  <= pwdata[0];
				REG_BL:  cfg_q.bl  <= pwdata[0];
				REG_IND: cfg_q.ind <= pwdata[0];
				REG_IGN: cfg_q.ign <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NL:  prdata = {31'd0, cfg_q.nl};
			REG_BL:  prdata = {31'd0, cfg_q.bl};
			REG_IND: prdata = {31'd0, cfg_q.ind};
			REG_IGN: prdata = {26'd0, cfg_q.ign};
			default: prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/tps_ctrl.sv]
// Sequencer: walks the event steps of one item and drives the datapath.
`default_nettype none
module tps_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tps_pkg::stat_t st,
	output tps_pkg::cmd_t       cmd
);
	import tps_pkg::*;

	ctl_state_t state_q, state_d;
	ctl_state_t cont;
	logic       adv;
	logic       emit_c;
	ev_kind_t   kind_c;
	src_t       src_c;
	op_t        op_c;

	assign in_ready = (state_q == ST_IDLE);
	assign adv      = (state_q == ST_IDLE) ? in_valid : st.out_free;

	// where a line end goes once its own events are out
	always_comb begin
		if (st.req == REQ_END) begin
			cont = ST_SECEND;
		end else if (st.u_lf) begin
			cont = ST_FINISH;
		end else begin
			cont = ST_TXT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (adv) begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (st.req)
					REQ_START: state_d = st.title_req ? ST_TBEGIN : ST_CH_PBEGIN;
					REQ_TEXT:  state_d = st.cr_pend ? ST_LE_TEXT : ST_TXT;
					REQ_END:   state_d = st.cr_pend ? ST_LE_TEXT : ST_SECEND;
					default:   state_d = ST_FINISH;
				endcase
			end
			ST_TXT: begin
				if (st.u_lf) begin
					state_d = ST_LE_TEXT;
				end else if (st.u_cr || (st.u_blank && st.line_blank)) begin
					state_d = ST_FINISH;
				end else if (st.line_blank && st.ind_brk) begin
					state_d = ST_IND_PEND;
				end else if (st.line_blank && !st.lead_empty) begin
					state_d = ST_LEAD;
				end else begin
					state_d = ST_UNIT;
				end
			end
			ST_IND_PEND:   state_d = ST_IND_PBEGIN;
			ST_IND_PBEGIN: state_d = st.lead_empty ? ST_UNIT : ST_LEAD;
			ST_LEAD:       state_d = st.lead_last ? ST_UNIT : ST_LEAD;
			ST_UNIT:       state_d = ST_FINISH;
			ST_LE_TEXT: begin
				if (st.title_act) begin
					state_d = ST_LE_TEND;
				end else if (st.brk) begin
					state_d = ST_LE_PEND;
				end else begin
					state_d = cont;
				end
			end
			ST_LE_TEND:   state_d = ST_LE_PEND;
			ST_LE_PEND:   state_d = ST_LE_PBEGIN;
			ST_LE_PBEGIN: state_d = cont;
			ST_SECEND:    state_d = ST_END_PEND;
			ST_END_PEND:  state_d = ST_FINISH;
			ST_TBEGIN:    state_d = ST_CH_PBEGIN;
			ST_CH_PBEGIN: state_d = ST_FINISH;
			ST_FINISH:    state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit_c = 1'b0;
		kind_c = EV_TEXT;
		src_c  = SRC_ZERO;
		op_c   = OP_NONE;
		case (state_q)
			ST_IDLE:     op_c = OP_LATCH;
			ST_DISPATCH: begin
				case (st.req)
					REQ_START: op_c = OP_CHAPTER;
					REQ_TEXT:  op_c = st.cr_pend ? OP_CLR_CR : OP_NONE;
					REQ_END:   op_c = st.cr_pend ? OP_CLR_CR : OP_NONE;
					default:   op_c = OP_NONE;
				endcase
			end
			ST_TXT: begin
				if (st.u_lf) begin
					op_c = OP_NONE;
				end else if (st.u_cr) begin
					op_c = OP_SET_CR;
				end else if (st.u_blank && st.line_blank) begin
					op_c = OP_LEAD_ADD;
				end else if (st.line_blank) begin
					op_c = OP_LINE_START;
				end
			end
			ST_IND_PEND:   begin emit_c = 1'b1; kind_c = EV_PEND; end
			ST_IND_PBEGIN: begin emit_c = 1'b1; kind_c = EV_PBEGIN; end
			ST_LEAD: begin
				emit_c = 1'b1;
				src_c  = SRC_LEAD;
				op_c   = OP_LEAD_NEXT;
			end
			ST_UNIT: begin
				emit_c = 1'b1;
				src_c  = SRC_UNIT;
			end
			ST_LE_TEXT: begin
				// the terminator shows only when the line carried text
				emit_c = !st.line_blank;
				src_c  = SRC_TERM;
				op_c   = OP_LINE_END;
			end
			ST_LE_TEND: begin
				emit_c = 1'b1;
				kind_c = EV_TEND;
				op_c   = OP_CLR_TITLE;
			end
			ST_LE_PEND:   begin emit_c = 1'b1; kind_c = EV_PEND; end
			ST_LE_PBEGIN: begin emit_c = 1'b1; kind_c = EV_PBEGIN; end
			ST_SECEND: begin
				emit_c = 1'b1;
				kind_c = EV_SECEND;
				op_c   = OP_CLR_TITLE;
			end
			ST_END_PEND:  begin emit_c = 1'b1; kind_c = EV_PEND; end
			ST_TBEGIN:    begin emit_c = 1'b1; kind_c = EV_TBEGIN; end
			ST_CH_PBEGIN: begin emit_c = 1'b1; kind_c = EV_PBEGIN; end
			ST_FINISH:    op_c = OP_FINISH;
			default:      op_c = OP_NONE;
		endcase
	end

	assign cmd.emit = emit_c & adv;
	assign cmd.kind = kind_c;
	assign cmd.src  = src_c;
	assign cmd.op   = adv ? op_c : OP_NONE;

endmodule
`default_nettype wire

[hw/rtl/tps_dp.sv]
// Datapath: line state, leading whitespace store, hold stage and output register.
`default_nettype none
module tps_dp #(
	parameter int LEAD_DEPTH = tps_pkg::LEAD_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tps_pkg::cfg_t cfg,
	input  wire tps_pkg::cmd_t cmd,
	output tps_pkg::stat_t     st,
	input  wire logic [1:0]    req_type,
	input  wire logic [15:0]   code_unit,
	input  wire logic          has_title,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [2:0]         event_kind,
	output logic [15:0]        text_unit,
	output logic               last
);
	import tps_pkg::*;

	localparam int LEN_W = $clog2(LEAD_DEPTH + 1);
	localparam int IDX_W = (LEAD_DEPTH > 1) ? $clog2(LEAD_DEPTH) : 1;

	// latched item
	logic [1:0]  req_q;
	logic [15:0] unit_q;
	logic        title_req_q;

	// line state
	logic             line_blank_q;
	logic [7:0]       run_q;
	logic [11:0]      count_q;
	logic [LEN_W-1:0] lead_len_q;
	logic [LEN_W-1:0] idx_q, idx_d;
	logic             title_q;
	logic             cr_q;

	logic             lead_mem [LEAD_DEPTH];
	logic             lead_rd_q;

	// hold stage: one event kept back until it is known whether it is the last
	logic        hold_v_q;
	ev_kind_t    hold_kind_q;
	logic [15:0] hold_unit_q;

	logic        out_valid_q;
	ev_kind_t    out_kind_q;
	logic [15:0] out_unit_q;
	logic        out_last_q;

	logic        u_lf, u_cr, u_tab, u_blank;
	logic [15:0] unit_norm, term, ev_unit;
	logic [12:0] count_sum;
	logic        out_free, push, flush;

	assign u_lf      = (unit_q == CU_LF);
	assign u_cr      = (unit_q == CU_CR);
	assign u_tab     = (unit_q == CU_TAB);
	assign u_blank   = u_tab || (unit_q == CU_VT) || (unit_q == CU_FF) || (unit_q == CU_SPACE);
	assign unit_norm = (u_blank && !u_tab) ? CU_SPACE : unit_q;
	assign term      = ((req_q == REQ_TEXT) && u_lf) ? CU_LF : CU_CR;
	assign count_sum = {1'b0, count_q} + (u_tab ? (13'(cfg.ign) + 13'd1) : 13'd1);

	always_comb begin
		case (cmd.src)
			SRC_TERM: ev_unit = term;
			SRC_LEAD: ev_unit = lead_rd_q ? CU_TAB : CU_SPACE;
			SRC_UNIT: ev_unit = unit_norm;
			default:  ev_unit = 16'd0;
		endcase
	end

	always_comb begin
		case (cmd.op)
			OP_LINE_START: idx_d = '0;
			OP_LEAD_NEXT:  idx_d = idx_q + LEN_W'(1);
			default:       idx_d = idx_q;
		endcase
	end

	assign out_free = !out_valid_q || out_ready;
	assign flush    = (cmd.op == OP_FINISH) && hold_v_q;
	assign push     = (cmd.emit && hold_v_q) || flush;

	assign st.out_free   = out_free;
	assign st.req        = req_q;
	assign st.title_req  = title_req_q;
	assign st.line_blank = line_blank_q;
	assign st.cr_pend    = cr_q;
	assign st.title_act  = title_q;
	assign st.u_lf       = u_lf;
	assign st.u_cr       = u_cr;
	assign st.u_blank    = u_blank;
	// a blank line always leaves a nonzero run behind
	assign st.brk        = cfg.nl || (cfg.bl && line_blank_q);
	assign st.ind_brk    = cfg.ind && (count_q > {6'd0, cfg.ign});
	assign st.lead_empty = (lead_len_q == '0);
	assign st.lead_last  = ((idx_q + LEN_W'(1)) == lead_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_blank_q <= 1'b1;
			run_q        <= 8'd0;
			count_q      <= 12'd0;
			lead_len_q   <= '0;
			idx_q        <= '0;
			title_q      <= 1'b0;
			cr_q         <= 1'b0;
			hold_v_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			idx_q <= idx_d;
			case (cmd.op)
				OP_CHAPTER: begin
					cr_q         <= 1'b0;
					line_blank_q <= 1'b1;
					count_q      <= 12'd0;
					lead_len_q   <= '0;
					run_q        <= 8'd0;
					title_q      <= title_req_q;
				end
				OP_CLR_CR: cr_q <= 1'b0;
				OP_SET_CR: cr_q <= 1'b1;
				OP_LEAD_ADD: begin
					count_q <= (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[11:0];
					if (lead_len_q < LEN_W'(LEAD_DEPTH)) begin
						lead_len_q <= lead_len_q + LEN_W'(1);
					end
				end
				OP_LINE_START: line_blank_q <= 1'b0;
				OP_LINE_END: begin
					if (!line_blank_q) begin
						run_q <= 8'd0;
					end else if (run_q != RUN_MAX) begin
						run_q <= run_q + 8'd1;
					end
					line_blank_q <= 1'b1;
					count_q      <= 12'd0;
					lead_len_q   <= '0;
				end
				OP_CLR_TITLE: title_q <= 1'b0;
				default: ;
			endcase

			if (cmd.emit) begin
				hold_v_q <= 1'b1;
			end else if (flush) begin
				hold_v_q <= 1'b0;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			req_q       <= req_type;
			unit_q      <= code_unit;
			title_req_q <= has_title;
		end
		if ((cmd.op == OP_LEAD_ADD) && (lead_len_q < LEN_W'(LEAD_DEPTH))) begin
			lead_mem[lead_len_q[IDX_W-1:0]] <= u_tab;
		end
		// read follows the next index, so lead_rd_q matches idx_q
		lead_rd_q <= lead_mem[idx_d[IDX_W-1:0]];
		if (cmd.emit) begin
			hold_kind_q <= cmd.kind;
			hold_unit_q <= ev_unit;
		end
		if (push) begin
			out_kind_q <= hold_kind_q;
			out_unit_q <= hold_unit_q;
			out_last_q <= flush;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_kind = out_kind_q;
	assign text_unit  = out_unit_q;
	assign last       = out_last_q;

endmodule
`default_nettype wire

[hw/rtl/text_paragraph_segmenter.sv]
// Top level of the text paragraph segmenter.
//
//  Channel  Handshake            Payload
//  -------  -------------------  ------------------------------------
//  in       in_valid / in_ready  req_type, code_unit, has_title
//  out      out_valid/out_ready  event_kind, text_unit, last
//  cfg      psel/penable/pready  pwrite, paddr, pwdata, prdata
//
// One item at a time: an item passes through accept, decode and finish, plus a step
// per result and per silent step of the sequencer.
// Held leading whitespace leaves one unit per cycle (memory port) unless out stalls.
// Results leave through an output register; a stalled result freezes the busy sequencer.
// Reset clears line state, title and carriage-return flags; registers take reset values.
`default_nettype none
module text_paragraph_segmenter #(
	parameter int LEAD_DEPTH = tps_pkg::LEAD_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] code_unit,
	input  wire logic        has_title,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       event_kind,
	output logic [15:0]      text_unit,
	output logic             last
);
	import tps_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t st;

	tps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	tps_dp #(
		.LEAD_DEPTH (LEAD_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.st         (st),
		.req_type   (req_type),
		.code_unit  (code_unit),
		.has_title  (has_title),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.text_unit  (text_unit),
		.last       (last)
	);

endmodule
`default_nettype wire

[hw/rtl/tps_checker.sv]
// Port-level checks for the text paragraph segmenter, bound to the top level.
`default_nettype none
module tps_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [3:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  req_type,
	input wire logic [15:0] code_unit,
	input wire logic        has_title,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [2:0]  event_kind,
	input wire logic [15:0] text_unit,
	input wire logic        last
);
	import tps_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(event_kind) && $stable(text_unit) && $stable(last))
		else $error("result beat changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

	a_marker_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind != EV_TEXT) |-> text_unit == 16'd0)
		else $error("marker event carries a unit");

	a_secend_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_SECEND) |-> !last)
		else $error("section end marked as last beat");

endmodule

bind text_paragraph_segmenter tps_checker u_tps_checker (.*);
`default_nettype wire
